@@ rtl/core/qsr_pkg.sv @@
// qsr_pkg: shared widths, codes, types and helpers of the qpsk sync phase resolver
`default_nettype none
package qsr_pkg;

    localparam int BYTE_W    = 8;
    localparam int SYNC_W    = 64;
    localparam int LEN_W     = 7;
    localparam int TOL_W     = 8;
    localparam int PHASE_W   = 4;
    localparam int SUM_W     = 8;
    localparam int CAND_W    = 10;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_I   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_Q   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = CFG_IDX_W'(3);

    localparam logic [LEN_W-1:0] MIN_SYNC_LEN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] RST_SYNC_LEN   = LEN_W'(32);

    localparam logic [PHASE_W-1:0] PH_UNKNOWN = 4'd0;
    localparam logic [PHASE_W-1:0] PH_R0      = 4'd1;
    localparam logic [PHASE_W-1:0] PH_R90     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_R180    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_R270    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_S0      = 4'd5;
    localparam logic [PHASE_W-1:0] PH_S90     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_S180    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_S270    = 4'd8;

    // weight code {nonzero, positive}
    localparam logic [1:0] W_ZERO = 2'b00;
    localparam logic [1:0] W_NEG  = 2'b10;
    localparam logic [1:0] W_POS  = 2'b11;

    typedef struct packed {
        logic [SYNC_W-1:0] sync_i;
        logic [SYNC_W-1:0] sync_q;
        logic [LEN_W-1:0]  len;
        logic [TOL_W-1:0]  tol;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]       i_raw;
        logic [BYTE_W-1:0]       q_raw;
        logic                    elig;
        logic signed [SUM_W-1:0] ii;
        logic signed [SUM_W-1:0] iq;
        logic signed [SUM_W-1:0] qi;
        logic signed [SUM_W-1:0] qq;
    } t_qent;

    function automatic logic [1:0] weight_of(input logic [BYTE_W-1:0] b);
        logic [1:0] w;
        w = W_ZERO;
        if (b == BYTE_W'(0)) w = W_NEG;
        else if (b == BYTE_W'(1)) w = W_POS;
        return w;
    endfunction

    function automatic logic [BYTE_W-1:0] inv_bit(input logic [BYTE_W-1:0] b);
        return {{(BYTE_W-1){1'b0}}, ~b[0]};
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/qsr_ifs.sv @@
// qsr_ifs: handshake channels of the qpsk sync phase resolver
`default_nettype none
interface qsr_in_if import qsr_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] i_sample;
    logic [BYTE_W-1:0] q_sample;
    logic              hold;
    modport source (output valid, i_sample, q_sample, hold, input ready);
    modport sink   (input valid, i_sample, q_sample, hold, output ready);
endinterface

interface qsr_out_if import qsr_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  first_out;
    logic [BYTE_W-1:0]  second_out;
    logic [PHASE_W-1:0] phase_code;
    logic               phase_found;
    modport source (output valid, first_out, second_out, phase_code, phase_found, input ready);
    modport sink   (input valid, first_out, second_out, phase_code, phase_found, output ready);
endinterface

interface qsr_cfg_if import qsr_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SYNC_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/qsr_front.sv @@
// qsr_front: symbol windows and pipelined correlation against the sync word
`default_nettype none
module qsr_front import qsr_pkg::*; #(
    parameter int MAX_SYNC_LEN = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    qsr_in_if.sink     i_in,
    output logic       o_push,
    output t_qent      o_push_word,
    input  wire logic  i_q_full
);

    localparam int GRP  = 8;
    localparam int NGRP = (MAX_SYNC_LEN + GRP - 1) / GRP;
    localparam int PW   = $clog2(GRP + 1) + 1;
    localparam logic signed [PW-1:0] P_ONE  = PW'(1);
    localparam logic signed [PW-1:0] P_MONE = -PW'(1);

    typedef struct packed {
        logic [BYTE_W-1:0] i_raw;
        logic [BYTE_W-1:0] q_raw;
        logic              elig;
    } t_item;

    logic                    enable;
    logic                    accept;
    logic [LEN_W-1:0]        n_fill;
    logic [LEN_W-1:0]        r_fill;
    logic [MAX_SYNC_LEN-1:0] rev_i, rev_q;
    logic [LEN_W-1:0]        shamt;
    logic [MAX_SYNC_LEN-1:0] n_pat_i, n_pat_q, n_mask;
    logic [MAX_SYNC_LEN-1:0] r_pat_i, r_pat_q, r_mask;
    logic [1:0]              r_win_i [MAX_SYNC_LEN];
    logic [1:0]              r_win_q [MAX_SYNC_LEN];
    logic                    r_a_vld, r_b_vld, r_c_vld;
    t_item                   r_a_item, r_b_item, r_c_item;
    logic signed [PW-1:0]    n_pii [NGRP];
    logic signed [PW-1:0]    n_piq [NGRP];
    logic signed [PW-1:0]    n_pqi [NGRP];
    logic signed [PW-1:0]    n_pqq [NGRP];
    logic signed [PW-1:0]    r_pii [NGRP];
    logic signed [PW-1:0]    r_piq [NGRP];
    logic signed [PW-1:0]    r_pqi [NGRP];
    logic signed [PW-1:0]    r_pqq [NGRP];
    logic signed [SUM_W-1:0] n_ii, n_iq, n_qi, n_qq;
    logic signed [SUM_W-1:0] r_ii, r_iq, r_qi, r_qq;

    assign enable     = !r_c_vld || !i_q_full;
    assign accept     = i_in.valid && enable;
    assign i_in.ready = enable;

    assign n_fill = (r_fill < LEN_W'(MAX_SYNC_LEN)) ? r_fill + LEN_W'(1) : r_fill;

    // sync pattern aligned so that window position p meets sync symbol len-1-p
    always_comb begin
        for (int j = 0; j < MAX_SYNC_LEN; j++) begin
            rev_i[j]  = i_cfg.sync_i[MAX_SYNC_LEN-1-j];
            rev_q[j]  = i_cfg.sync_q[MAX_SYNC_LEN-1-j];
            n_mask[j] = LEN_W'(j) < i_cfg.len;
        end
        shamt   = LEN_W'(MAX_SYNC_LEN) - i_cfg.len;
        n_pat_i = rev_i >> shamt;
        n_pat_q = rev_q >> shamt;
    end

    always_ff @(posedge i_clk) begin
        r_pat_i <= n_pat_i;
        r_pat_q <= n_pat_q;
        r_mask  <= n_mask;
    end

    // window shift and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int p = 0; p < MAX_SYNC_LEN; p++) begin
                r_win_i[p] <= W_ZERO;
                r_win_q[p] <= W_ZERO;
            end
        end else if (accept) begin
            r_fill     <= n_fill;
            r_win_i[0] <= weight_of(i_in.i_sample);
            r_win_q[0] <= weight_of(i_in.q_sample);
            for (int p = 1; p < MAX_SYNC_LEN; p++) begin
                r_win_i[p] <= r_win_i[p-1];
                r_win_q[p] <= r_win_q[p-1];
            end
        end
    end

    // group partial sums
    always_comb begin
        int p;
        for (int g = 0; g < NGRP; g++) begin
            n_pii[g] = '0;
            n_piq[g] = '0;
            n_pqi[g] = '0;
            n_pqq[g] = '0;
            for (int e = 0; e < GRP; e++) begin
                p = g * GRP + e;
                if (p < MAX_SYNC_LEN) begin
                    if (r_mask[p] && r_win_i[p][1]) begin
                        n_pii[g] = n_pii[g] + ((r_win_i[p][0] == r_pat_i[p]) ? P_ONE : P_MONE);
                        n_piq[g] = n_piq[g] + ((r_win_i[p][0] == r_pat_q[p]) ? P_ONE : P_MONE);
                    end
                    if (r_mask[p] && r_win_q[p][1]) begin
                        n_pqi[g] = n_pqi[g] + ((r_win_q[p][0] == r_pat_i[p]) ? P_ONE : P_MONE);
                        n_pqq[g] = n_pqq[g] + ((r_win_q[p][0] == r_pat_q[p]) ? P_ONE : P_MONE);
                    end
                end
            end
        end
    end

    // group totals
    always_comb begin
        n_ii = '0;
        n_iq = '0;
        n_qi = '0;
        n_qq = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_ii = n_ii + SUM_W'(r_pii[g]);
            n_iq = n_iq + SUM_W'(r_piq[g]);
            n_qi = n_qi + SUM_W'(r_pqi[g]);
            n_qq = n_qq + SUM_W'(r_pqq[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (enable) begin
            r_a_vld <= accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_item.i_raw <= i_in.i_sample;
            r_a_item.q_raw <= i_in.q_sample;
            r_a_item.elig  <= !i_in.hold && (n_fill >= i_cfg.len);
        end
        if (enable) begin
            r_b_item <= r_a_item;
            r_c_item <= r_b_item;
            r_pii    <= n_pii;
            r_piq    <= n_piq;
            r_pqi    <= n_pqi;
            r_pqq    <= n_pqq;
            r_ii     <= n_ii;
            r_iq     <= n_iq;
            r_qi     <= n_qi;
            r_qq     <= n_qq;
        end
    end

    assign o_push            = r_c_vld && !i_q_full;
    assign o_push_word.i_raw = r_c_item.i_raw;
    assign o_push_word.q_raw = r_c_item.q_raw;
    assign o_push_word.elig  = r_c_item.elig;
    assign o_push_word.ii    = r_ii;
    assign o_push_word.iq    = r_iq;
    assign o_push_word.qi    = r_qi;
    assign o_push_word.qq    = r_qq;

endmodule
`default_nettype wire

@@ rtl/core/qsr_queue.sv @@
// qsr_queue: short word queue between correlation and phase decision
`default_nettype none
module qsr_queue import qsr_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_push_word,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_qent      o_head,
    output logic       o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qent          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_word;
    end

endmodule
`default_nettype wire

@@ rtl/core/qsr_back.sv @@
// qsr_back: candidate phase selection, phase latch and symbol correction
`default_nettype none
module qsr_back import qsr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_qent i_head,
    input  wire logic  i_empty,
    output logic       o_pop,
    qsr_out_if.source  o_out
);

    logic signed [CAND_W-1:0] ii, iq, qi, qq;
    logic signed [CAND_W-1:0] cand [8];
    logic signed [CAND_W-1:0] top, thr;
    logic [PHASE_W-1:0]       sel;
    logic                     found;
    logic [PHASE_W-1:0]       n_phase;
    logic [PHASE_W-1:0]       r_phase;
    logic [BYTE_W-1:0]        n_first, n_second;
    logic                     r_o_vld;
    logic [BYTE_W-1:0]        r_first, r_second;
    logic [PHASE_W-1:0]       r_code;
    logic                     r_found;

    assign o_pop = !i_empty && (!r_o_vld || o_out.ready);

    always_comb begin
        ii = CAND_W'(i_head.ii);
        iq = CAND_W'(i_head.iq);
        qi = CAND_W'(i_head.qi);
        qq = CAND_W'(i_head.qq);
        cand[0] = ii + qq;
        cand[1] = qi - iq;
        cand[2] = -ii - qq;
        cand[3] = iq - qi;
        cand[4] = iq + qi;
        cand[5] = ii - qq;
        cand[6] = -iq - qi;
        cand[7] = qq - ii;
        top = signed'(CAND_W'({i_cfg.len, 1'b0}));
        thr = top - signed'(CAND_W'(i_cfg.tol));
        sel   = PH_UNKNOWN;
        found = 1'b0;
        // lowest-numbered candidate wins
        for (int c = 7; c >= 0; c--) begin
            if (cand[c] >= thr && cand[c] <= top) begin
                sel   = PHASE_W'(c + 1);
                found = 1'b1;
            end
        end
        n_phase = (i_head.elig && found) ? sel : r_phase;
    end

    always_comb begin
        case (n_phase)
            PH_R0:   begin n_first = i_head.i_raw;          n_second = i_head.q_raw;          end
            PH_R90:  begin n_first = i_head.q_raw;          n_second = inv_bit(i_head.i_raw); end
            PH_R180: begin n_first = inv_bit(i_head.i_raw); n_second = inv_bit(i_head.q_raw); end
            PH_R270: begin n_first = inv_bit(i_head.q_raw); n_second = i_head.i_raw;          end
            PH_S0:   begin n_first = i_head.q_raw;          n_second = i_head.i_raw;          end
            PH_S90:  begin n_first = i_head.i_raw;          n_second = inv_bit(i_head.q_raw); end
            PH_S180: begin n_first = inv_bit(i_head.q_raw); n_second = inv_bit(i_head.i_raw); end
            PH_S270: begin n_first = inv_bit(i_head.i_raw); n_second = i_head.q_raw;          end
            default: begin n_first = '0;                    n_second = '0;                    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UNKNOWN;
            r_o_vld <= 1'b0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_code   <= n_phase;
            r_found  <= i_head.elig && found;
        end
    end

    assign o_out.valid       = r_o_vld;
    assign o_out.first_out   = r_first;
    assign o_out.second_out  = r_second;
    assign o_out.phase_code  = r_code;
    assign o_out.phase_found = r_found;

endmodule
`default_nettype wire

@@ rtl/core/qpsk_sync_phase_resolver_top.sv @@
// qpsk_sync_phase_resolver_top: qpsk phase ambiguity resolver by sync word correlation
//
// i_in takes one hard-decided symbol per word (i_sample, q_sample, hold).
// o_out gives one corrected word per input word, in order: first_out,
// second_out, phase_code and phase_found.
// i_cfg writes the sync i bits, sync q bits, sync length and tolerance;
// it is always ready; the user must write it only while no word is in flight,
// which the block does not enforce. From the accepting edge a word passes the
// window, two correlation stages, the queue and the output register to o_out.valid.
// Throughput is one word per cycle while the queue is not full, set by the
// pipelined correlation tree and the phase decision before the output register.
// When o_out stalls, the output register and the queue absorb words; once
// the queue fills, the correlation pipeline stops and i_in.ready drops.
// Reset clears the windows, fill count, phase (unknown), pipeline valid flags and
// queue pointers, and sets sync length to 32 with zero patterns and tolerance.
`default_nettype none
module qpsk_sync_phase_resolver_top import qsr_pkg::*; #(
    parameter int MAX_SYNC_LEN = 64,
    parameter int QUEUE_DEPTH  = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qsr_cfg_if.sink    i_cfg,
    qsr_in_if.sink     i_in,
    qsr_out_if.source  o_out
);

    logic [SYNC_W-1:0] r_sync_i, r_sync_q;
    logic [LEN_W-1:0]  r_len;
    logic [TOL_W-1:0]  r_tol;
    logic [LEN_W-1:0]  eff_len;
    t_cfg              cfg;
    logic              push, pop, q_full, q_empty;
    t_qent             push_word, head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_i <= '0;
            r_sync_q <= '0;
            r_len    <= RST_SYNC_LEN;
            r_tol    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SYNC_I:   r_sync_i <= i_cfg.data;
                REG_SYNC_Q:   r_sync_q <= i_cfg.data;
                REG_SYNC_LEN: r_len    <= i_cfg.data[LEN_W-1:0];
                REG_TOL:      r_tol    <= i_cfg.data[TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        eff_len = r_len;
        if (r_len < MIN_SYNC_LEN) eff_len = MIN_SYNC_LEN;
        else if (r_len > LEN_W'(MAX_SYNC_LEN)) eff_len = LEN_W'(MAX_SYNC_LEN);
        cfg.sync_i = r_sync_i;
        cfg.sync_q = r_sync_q;
        cfg.len    = eff_len;
        cfg.tol    = r_tol;
    end

    qsr_front #(.MAX_SYNC_LEN(MAX_SYNC_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .o_push      (push),
        .o_push_word (push_word),
        .i_q_full    (q_full)
    );

    qsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (q_empty)
    );

    qsr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

@@ dv/resolver_sb_pkg.sv @@
// resolver_sb_pkg: predictor and checker of corrected words for the sync phase resolver bench
package resolver_sb_pkg;
    import qsr_pkg::*;

    localparam int WINDOW_DEPTH = 64;

    localparam logic [PHASE_W-1:0] PHASE_BY_RANK [8] = '{
        PH_R0, PH_R90, PH_R180, PH_R270, PH_S0, PH_S90, PH_S180, PH_S270
    };

    typedef struct {
        logic [BYTE_W-1:0]  first_out;
        logic [BYTE_W-1:0]  second_out;
        logic [PHASE_W-1:0] phase_code;
        logic               phase_found;
    } corrected_word_t;

    class phase_scoreboard;
        logic [SYNC_W-1:0]  sync_i;
        logic [SYNC_W-1:0]  sync_q;
        logic [LEN_W-1:0]   sync_len;
        logic [TOL_W-1:0]   tol;
        int                 i_win [WINDOW_DEPTH];
        int                 q_win [WINDOW_DEPTH];
        int                 fill;
        logic [PHASE_W-1:0] phase;
        corrected_word_t    expected_words [$];
        int                 errors;

        function new();
            sync_i = '0;
            sync_q = '0;
            sync_len = RST_SYNC_LEN;
            tol = '0;
            foreach (i_win[k]) begin
                i_win[k] = 0;
                q_win[k] = 0;
            end
            fill = 0;
            phase = PH_UNKNOWN;
            errors = 0;
        endfunction

        function int active_len();
            if (sync_len < MIN_SYNC_LEN) return int'(MIN_SYNC_LEN);
            if (int'(sync_len) > WINDOW_DEPTH) return WINDOW_DEPTH;
            return int'(sync_len);
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SYNC_W-1:0] value);
            case (idx)
                REG_SYNC_I:   sync_i = value;
                REG_SYNC_Q:   sync_q = value;
                REG_SYNC_LEN: sync_len = value[LEN_W-1:0];
                REG_TOL:      tol = value[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        static function int symbol_weight(logic [BYTE_W-1:0] b);
            if (b == 8'd0) return -1;
            if (b == 8'd1) return 1;
            return 0;
        endfunction

        static function logic [BYTE_W-1:0] flip(logic [BYTE_W-1:0] b);
            return {7'b0, ~b[0]};
        endfunction

        function void note_symbol(logic [BYTE_W-1:0] ib, logic [BYTE_W-1:0] qb, logic h);
            int n, top, thr, ii, iq, qi, qq, wi, wq, si, sq, k, c;
            int cand [8];
            logic hit;
            corrected_word_t w;
            n = active_len();
            for (k = WINDOW_DEPTH - 1; k > 0; k--) begin
                i_win[k] = i_win[k-1];
                q_win[k] = q_win[k-1];
            end
            i_win[0] = symbol_weight(ib);
            q_win[0] = symbol_weight(qb);
            if (fill < WINDOW_DEPTH) fill++;
            hit = 1'b0;
            if (!h && fill >= n) begin
                ii = 0;
                iq = 0;
                qi = 0;
                qq = 0;
                top = 2 * n;
                thr = top - int'(tol);
                // oldest symbol in the window lines up with sync symbol 0
                for (k = 0; k < n; k++) begin
                    wi = i_win[n-1-k];
                    wq = q_win[n-1-k];
                    si = sync_i[k] ? 1 : -1;
                    sq = sync_q[k] ? 1 : -1;
                    ii += wi * si;
                    iq += wi * sq;
                    qi += wq * si;
                    qq += wq * sq;
                end
                cand[0] = ii + qq;
                cand[1] = qi - iq;
                cand[2] = -ii - qq;
                cand[3] = iq - qi;
                cand[4] = iq + qi;
                cand[5] = ii - qq;
                cand[6] = -iq - qi;
                cand[7] = qq - ii;
                for (c = 0; c < 8; c++) begin
                    if (!hit && cand[c] >= thr && cand[c] <= top) begin
                        phase = PHASE_BY_RANK[c];
                        hit = 1'b1;
                    end
                end
            end
            case (phase)
                PH_R0: begin
                    w.first_out = ib;
                    w.second_out = qb;
                end
                PH_R90: begin
                    w.first_out = qb;
                    w.second_out = flip(ib);
                end
                PH_R180: begin
                    w.first_out = flip(ib);
                    w.second_out = flip(qb);
                end
                PH_R270: begin
                    w.first_out = flip(qb);
                    w.second_out = ib;
                end
                PH_S0: begin
                    w.first_out = qb;
                    w.second_out = ib;
                end
                PH_S90: begin
                    w.first_out = ib;
                    w.second_out = flip(qb);
                end
                PH_S180: begin
                    w.first_out = flip(qb);
                    w.second_out = flip(ib);
                end
                PH_S270: begin
                    w.first_out = flip(ib);
                    w.second_out = qb;
                end
                default: begin
                    w.first_out = '0;
                    w.second_out = '0;
                end
            endcase
            w.phase_code = phase;
            w.phase_found = hit;
            expected_words.push_back(w);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [BYTE_W-1:0] f, logic [BYTE_W-1:0] s,
                                 logic [PHASE_W-1:0] code, logic found);
            corrected_word_t w;
            if (expected_words.size() == 0) begin
                $display("%0t: word with none expected, actual %0d %0d %0d %0d",
                         $time, f, s, code, found);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            compare_field("first_out", w.first_out, f);
            compare_field("second_out", w.second_out, s);
            compare_field("phase_code", 8'(w.phase_code), 8'(code));
            compare_field("phase_found", 8'(w.phase_found), 8'(found));
        endfunction
    endclass

endpackage

@@ dv/tb.sv @@
// tb: drives symbols, sync settings and output stalls into the resolver and checks each word
module tb;
    import qsr_pkg::*;
    import resolver_sb_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int LIMIT_CYCLES     = 200000;
    localparam int CHOKE_CYCLES     = 80;
    localparam int TAIL_CYCLES      = 20;
    localparam int NUM_CONFIGS      = 10;
    localparam int WORDS_PER_CONFIG = 55;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   gaps_on = 1'b1;
    bit   choke_now = 1'b0;
    int   cycles = 0;
    int   sent_words = 0;

    qsr_cfg_if cfg_ch ();
    qsr_in_if  sym_ch ();
    qsr_out_if res_ch ();

    phase_scoreboard sb = new();

    qpsk_sync_phase_resolver_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (sym_ch),
        .o_out   (res_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready)
                sb.check_word(res_ch.first_out, res_ch.second_out,
                              res_ch.phase_code, res_ch.phase_found);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (sym_ch.valid && sym_ch.ready)
                sb.note_symbol(sym_ch.i_sample, sym_ch.q_sample, sym_ch.hold);
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (choke_now) begin
                choke_now = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
            end
            res_ch.ready <= !(gaps_on && $urandom_range(99) < 6);
        end
    end

    function automatic logic [BYTE_W-1:0] noise_byte();
        int r;
        r = $urandom_range(99);
        if (r < 80) return BYTE_W'($urandom_range(1));
        if (r < 85) return 8'hff;
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic logic [SYNC_W-1:0] random_pattern();
        return {$urandom, $urandom};
    endfunction

    // sync symbol as seen after the channel applies the given phase
    function automatic logic [15:0] rotated_symbol(logic [PHASE_W-1:0] ph, logic bi, logic bq);
        logic a, b;
        case (ph)
            PH_R0:   begin a = bi;  b = bq;  end
            PH_R90:  begin a = ~bq; b = bi;  end
            PH_R180: begin a = ~bi; b = ~bq; end
            PH_R270: begin a = bq;  b = ~bi; end
            PH_S0:   begin a = bq;  b = bi;  end
            PH_S90:  begin a = bi;  b = ~bq; end
            PH_S180: begin a = ~bq; b = ~bi; end
            default: begin a = ~bi; b = bq;  end
        endcase
        return {7'b0, a, 7'b0, b};
    endfunction

    task automatic send_symbol(input logic [BYTE_W-1:0] ib, input logic [BYTE_W-1:0] qb,
                               input logic h);
        while (gaps_on && $urandom_range(99) < 6) begin
            sym_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sym_ch.valid <= 1'b1;
        sym_ch.i_sample <= ib;
        sym_ch.q_sample <= qb;
        sym_ch.hold <= h;
        @(posedge clk);
        while (!sym_ch.ready) @(posedge clk);
        sent_words++;
    endtask

    task automatic send_sync_word(input logic [PHASE_W-1:0] ph, input bit noisy);
        logic [15:0]       pair;
        logic [BYTE_W-1:0] ib, qb;
        int                k, n;
        n = sb.active_len();
        for (k = 0; k < n; k++) begin
            pair = rotated_symbol(ph, sb.sync_i[k], sb.sync_q[k]);
            ib = pair[15:8];
            qb = pair[7:0];
            if (noisy && $urandom_range(15) == 0) ib = noise_byte();
            if (noisy && $urandom_range(15) == 0) qb = noise_byte();
            send_symbol(ib, qb, noisy && $urandom_range(99) < 4);
        end
    endtask

    task automatic wait_results_drained();
        sym_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SYNC_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic program_resolver(input logic [LEN_W-1:0] len, input logic [TOL_W-1:0] tol,
                                    input logic [SYNC_W-1:0] si, input logic [SYNC_W-1:0] sq);
        write_reg(REG_SYNC_I, si);
        write_reg(REG_SYNC_Q, sq);
        write_reg(REG_SYNC_LEN, SYNC_W'(len));
        write_reg(REG_TOL, SYNC_W'(tol));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [LEN_W-1:0]  len_val;
        logic [TOL_W-1:0]  tol_val;
        logic [SYNC_W-1:0] si_val, sq_val;
        int                cfg_no, p;

        sym_ch.valid <= 1'b0;
        sym_ch.i_sample <= '0;
        sym_ch.q_sample <= '0;
        sym_ch.hold <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_SYNC_I;
        cfg_ch.data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // window not yet full, phase unknown, byte extremes
        send_symbol(8'd0, 8'd0, 1'b0);
        send_symbol(8'd1, 8'd1, 1'b0);
        send_symbol(8'hff, 8'hff, 1'b1);
        send_symbol(8'd2, 8'hfe, 1'b0);
        send_symbol(8'h80, 8'h7f, 1'b0);
        wait_results_drained();

        // orthogonal two-symbol sync word, every phase in turn
        program_resolver(LEN_W'(2), '0, (random_pattern() << 2) | SYNC_W'(2'b11),
                         (random_pattern() << 2) | SYNC_W'(2'b01));
        for (p = 0; p < 8; p++) send_sync_word(PHASE_BY_RANK[p], 1'b0);
        send_symbol(8'd1, 8'd0, 1'b1);
        send_symbol(8'd0, 8'd1, 1'b1);

        for (cfg_no = 0; cfg_no < NUM_CONFIGS; cfg_no++) begin
            wait_results_drained();
            si_val = random_pattern();
            sq_val = random_pattern();
            tol_val = TOL_W'($urandom_range(4));
            case (cfg_no)
                0: begin len_val = LEN_W'(2); tol_val = '0; end
                1: begin len_val = LEN_W'(64); tol_val = '0; si_val = '1; sq_val = '0; end
                2: begin len_val = LEN_W'(127); tol_val = TOL_W'(255); end
                3: begin len_val = LEN_W'(0); tol_val = TOL_W'(1); end
                4: begin len_val = LEN_W'(1); tol_val = TOL_W'(128); end
                5: begin len_val = LEN_W'(3); tol_val = TOL_W'(2); end
                6: begin len_val = LEN_W'(7); tol_val = TOL_W'(3); sq_val = si_val; end
                7: begin len_val = LEN_W'(16); tol_val = TOL_W'(4); end
                8: begin
                    len_val = LEN_W'(2 * $urandom_range(1, 32));
                    tol_val = TOL_W'($urandom_range(10));
                end
                default: begin len_val = LEN_W'(33); tol_val = TOL_W'(6); end
            endcase
            program_resolver(len_val, tol_val, si_val, sq_val);
            gaps_on = (cfg_no != 3);
            // output held off while symbols keep coming, so the input backs up
            if (cfg_no == 3) choke_now = 1'b1;
            sent_words = 0;
            while (sent_words < WORDS_PER_CONFIG) begin
                if ($urandom_range(99) < 60)
                    send_sync_word(PHASE_BY_RANK[$urandom_range(7)], 1'b1);
                else
                    repeat ($urandom_range(1, 4))
                        send_symbol(noise_byte(), noise_byte(), $urandom_range(99) < 12);
            end
        end

        gaps_on = 1'b1;
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
